@@ src/mlgc_pkg.sv @@
// Package for the mask levels and gamma curve block.
// Register indexes, fixed-point constants and the log2 / exp2 curve tables.
// Used by mlgc_shape and mask_levels_gamma_curve.
package mlgc_pkg;

  typedef enum logic [2:0] {
    CfgInvertSample    = 3'd0,
    CfgInputBlack      = 3'd1,
    CfgInputWhite      = 3'd2,
    CfgResponseExp     = 3'd3,
    CfgOutputBlack     = 3'd4,
    CfgOutputWhite     = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] BlackMax   = 16'd65534;
  localparam logic [15:0] ExpMin     = 16'd205;
  localparam logic [15:0] ExpMax     = 16'd32768;
  localparam logic [16:0] OneQ16     = 17'd65536;
  localparam int          DisplaySteps = 255;
  // lv * 2 * steps > 2^32 is the same as lv > floor(2^32 / (2 * steps))
  localparam logic [31:0] DispThresh = 32'((64'd1 << 32) / (64'd2 * 64'(DisplaySteps)));

  // log2(1 + i/32) in Q1.16
  function automatic logic [16:0] log_tab(input logic [5:0] idx);
    logic [16:0] v;
    case (idx)
      6'd0:  v = 17'd0;      6'd1:  v = 17'd2909;   6'd2:  v = 17'd5732;
      6'd3:  v = 17'd8473;   6'd4:  v = 17'd11136;  6'd5:  v = 17'd13727;
      6'd6:  v = 17'd16248;  6'd7:  v = 17'd18704;  6'd8:  v = 17'd21098;
      6'd9:  v = 17'd23433;  6'd10: v = 17'd25711;  6'd11: v = 17'd27936;
      6'd12: v = 17'd30109;  6'd13: v = 17'd32234;  6'd14: v = 17'd34312;
      6'd15: v = 17'd36346;  6'd16: v = 17'd38336;  6'd17: v = 17'd40286;
      6'd18: v = 17'd42196;  6'd19: v = 17'd44068;  6'd20: v = 17'd45904;
      6'd21: v = 17'd47705;  6'd22: v = 17'd49472;  6'd23: v = 17'd51207;
      6'd24: v = 17'd52911;  6'd25: v = 17'd54584;  6'd26: v = 17'd56229;
      6'd27: v = 17'd57845;  6'd28: v = 17'd59434;  6'd29: v = 17'd60997;
      6'd30: v = 17'd62534;  6'd31: v = 17'd64047;  6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // 2^(-i/32) in Q1.16
  function automatic logic [16:0] exp_tab(input logic [5:0] idx);
    logic [16:0] v;
    case (idx)
      6'd0:  v = 17'd65536;  6'd1:  v = 17'd64132;  6'd2:  v = 17'd62757;
      6'd3:  v = 17'd61413;  6'd4:  v = 17'd60097;  6'd5:  v = 17'd58809;
      6'd6:  v = 17'd57549;  6'd7:  v = 17'd56316;  6'd8:  v = 17'd55109;
      6'd9:  v = 17'd53928;  6'd10: v = 17'd52773;  6'd11: v = 17'd51642;
      6'd12: v = 17'd50535;  6'd13: v = 17'd49452;  6'd14: v = 17'd48393;
      6'd15: v = 17'd47356;  6'd16: v = 17'd46341;  6'd17: v = 17'd45348;
      6'd18: v = 17'd44376;  6'd19: v = 17'd43425;  6'd20: v = 17'd42495;
      6'd21: v = 17'd41584;  6'd22: v = 17'd40693;  6'd23: v = 17'd39821;
      6'd24: v = 17'd38968;  6'd25: v = 17'd38133;  6'd26: v = 17'd37316;
      6'd27: v = 17'd36516;  6'd28: v = 17'd35734;  6'd29: v = 17'd34968;
      6'd30: v = 17'd34219;  6'd31: v = 17'd33486;  6'd32: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/mlgc_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the numerator's quotient must fit in QUO_W bits.
module mlgc_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8,
  parameter int QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic             vld_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic             vld_in;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_d;

    if (k == 0) begin : g_first
      // upper numerator bits are below the divisor when the quotient fits
      assign rem_in = DEN_W'(num_i >> QUO_W);
      assign low_in = num_i[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign rem_d = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= {low_in[QUO_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];

endmodule

@@ src/mlgc_shape.sv @@
// Power curve x^e as exp2(e * log2(x)) over five register stages.
// Depends on mlgc_pkg for the log2 and exp2 tables.
module mlgc_shape (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [16:0] norm_i,
  input  logic [15:0] exponent_i,
  output logic        valid_o,
  output logic [16:0] shaped_o
);

  // stage A: leading one and mantissa
  logic        a_vld_q, a_sp_q;
  logic [16:0] a_spv_q;
  logic [3:0]  a_p_q;
  logic [14:0] a_f_q;
  // stage B: -log2 of the normalized value
  logic        b_vld_q, b_sp_q;
  logic [16:0] b_spv_q;
  logic [20:0] b_nl_q;
  // stage C: times exponent
  logic        c_vld_q, c_sp_q;
  logic [16:0] c_spv_q;
  logic [36:0] c_prod_q;
  // stage D: exp2 of fraction
  logic        d_vld_q, d_sp_q, d_kill_q;
  logic [16:0] d_spv_q;
  logic [16:0] d_v_q;
  logic [4:0]  d_ip_q;
  // stage E: result
  logic        e_vld_q;
  logic [16:0] e_shaped_q;

  // stage A logic
  logic        a_sp_d;
  logic [16:0] a_spv_d;
  logic [3:0]  a_p_d;
  logic [15:0] a_norm_sh;

  always_comb begin
    a_p_d = '0;
    for (int b = 1; b < 16; b++) begin
      if (norm_i[b]) begin
        a_p_d = 4'(b);
      end
    end
    a_sp_d  = 1'b0;
    a_spv_d = '0;
    if (norm_i == '0) begin
      a_sp_d = 1'b1;
    end else if (norm_i >= mlgc_pkg::OneQ16) begin
      a_sp_d  = 1'b1;
      a_spv_d = mlgc_pkg::OneQ16;
    end
  end

  assign a_norm_sh = norm_i[15:0] << (4'd15 - a_p_d);

  // stage B logic
  logic [4:0]  b_i;
  logic [9:0]  b_r;
  logic [16:0] b_t0, b_t1;
  logic [22:0] b_mul;
  logic [16:0] b_t;
  logic [20:0] b_nl_d;

  assign b_i    = a_f_q[14:10];
  assign b_r    = a_f_q[9:0];
  assign b_t0   = mlgc_pkg::log_tab({1'b0, b_i});
  assign b_t1   = mlgc_pkg::log_tab({1'b0, b_i} + 6'd1);
  assign b_mul  = 23'(b_t1 - b_t0) * 23'(b_r) + 23'd512;
  assign b_t    = b_t0 + 17'(b_mul >> 10);
  assign b_nl_d = {5'(5'd16 - {1'b0, a_p_q}), 16'd0} - 21'(b_t);

  // stage D logic
  logic [36:0] d_arg;
  logic [8:0]  d_ipw;
  logic [15:0] d_fr;
  logic [16:0] d_e0, d_e1;
  logic [22:0] d_mul;

  assign d_arg = (c_prod_q + 37'd2048) >> 12;
  assign d_ipw = d_arg[24:16];
  assign d_fr  = d_arg[15:0];
  assign d_e0  = mlgc_pkg::exp_tab({1'b0, d_fr[15:11]});
  assign d_e1  = mlgc_pkg::exp_tab({1'b0, d_fr[15:11]} + 6'd1);
  assign d_mul = 23'(d_e0 - d_e1) * 23'(d_fr[10:0]) + 23'd1024;

  // stage E logic
  logic [17:0] e_rnd;
  logic [16:0] e_shaped_d;

  always_comb begin
    e_rnd = '0;
    if (d_ip_q != '0) begin
      e_rnd = 18'd1 << (d_ip_q - 5'd1);
    end
    e_shaped_d = 17'(({1'b0, d_v_q} + e_rnd) >> d_ip_q);
    if (d_kill_q) begin
      e_shaped_d = '0;
    end
    if (d_sp_q) begin
      e_shaped_d = d_spv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_sp_q     <= a_sp_d;
      a_spv_q    <= a_spv_d;
      a_p_q      <= a_p_d;
      a_f_q      <= a_norm_sh[14:0];
      b_sp_q     <= a_sp_q;
      b_spv_q    <= a_spv_q;
      b_nl_q     <= b_nl_d;
      c_sp_q     <= b_sp_q;
      c_spv_q    <= b_spv_q;
      c_prod_q   <= 37'(b_nl_q) * 37'(exponent_i);
      d_sp_q     <= c_sp_q;
      d_spv_q    <= c_spv_q;
      d_v_q      <= d_e0 - 17'(d_mul >> 11);
      d_kill_q   <= d_ipw >= 9'd17;
      d_ip_q     <= d_ipw[4:0];
      e_shaped_q <= e_shaped_d;
    end
  end

  assign valid_o  = e_vld_q;
  assign shaped_o = e_shaped_q;

endmodule

@@ src/mask_levels_gamma_curve.sv @@
// Top level of the mask levels and gamma curve block: registers, sample
// widening, input renormalization, output mapping. Uses mlgc_pkg, mlgc_div,
// mlgc_shape.
//
//   channel  valid        stall        payload
//   input    in_valid_i   in_stall_o   mask_sample_i
//   output   out_valid_o  out_stall_i  level_o, present_o
//   config   cfg_we_i     -            cfg_idx_i, cfg_data_i
//
// One request enters per cycle while no finished result is held; the pipe depth is
// set mostly by the bit-per-stage renormalization divider.
// Reset clears all valid bits and loads the register reset values; derived
// black point, span and clamped exponent are registered and follow a register write in the cycle after it.
// A stalled result holds every stage in place; nothing is dropped or repeated.
module mask_levels_gamma_curve #(
  parameter int SAMPLE_BITS = 8,
  parameter int LEVEL_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_BITS-1:0] mask_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  present_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i
);

  localparam int SmaxInt  = (1 << SAMPLE_BITS) - 1;
  localparam int WidenMul = 65535 / SmaxInt;
  localparam int WidenRem = 65535 % SmaxInt;
  localparam int TW       = 2 * SAMPLE_BITS;
  localparam logic [32:0] LevelRnd = 33'd1 << (31 - LEVEL_BITS);
  localparam logic [LEVEL_BITS-1:0] LevelMax = {LEVEL_BITS{1'b1}};

  logic adv;

  // configuration registers
  logic        invert_q;
  logic [15:0] in_black_q, in_white_q, exp_q, out_black_q, out_white_q;
  logic [15:0] black_q, span_q, exp_clamp_q;
  logic [15:0] black_d, white_d, exp_clamp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      in_black_q  <= 16'd0;
      in_white_q  <= 16'd65535;
      exp_q       <= 16'd4096;
      out_black_q <= 16'd0;
      out_white_q <= 16'd65535;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlgc_pkg::CfgInvertSample: invert_q    <= cfg_data_i[0];
        mlgc_pkg::CfgInputBlack:   in_black_q  <= cfg_data_i;
        mlgc_pkg::CfgInputWhite:   in_white_q  <= cfg_data_i;
        mlgc_pkg::CfgResponseExp:  exp_q       <= cfg_data_i;
        mlgc_pkg::CfgOutputBlack:  out_black_q <= cfg_data_i;
        mlgc_pkg::CfgOutputWhite:  out_white_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    black_d     = (in_black_q > mlgc_pkg::BlackMax) ? mlgc_pkg::BlackMax : in_black_q;
    white_d     = (in_white_q > black_d) ? in_white_q : black_d + 16'd1;
    exp_clamp_d = exp_q;
    if (exp_q < mlgc_pkg::ExpMin) begin
      exp_clamp_d = mlgc_pkg::ExpMin;
    end else if (exp_q > mlgc_pkg::ExpMax) begin
      exp_clamp_d = mlgc_pkg::ExpMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q     <= 16'd0;
      span_q      <= 16'd65535;
      exp_clamp_q <= 16'd4096;
    end else begin
      black_q     <= black_d;
      span_q      <= white_d - black_d;
      exp_clamp_q <= exp_clamp_d;
    end
  end

  // advance the whole pipe unless a finished result is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // widen the sample: round(s * 65535 / smax) as s * q0 + (s * r0 + smax/2) / smax,
  // the last division by 2^B - 1 done by folding the high digit onto the low one
  logic [TW-1:0]          w_t;
  logic [SAMPLE_BITS-1:0] w_hi, w_lo;
  logic [SAMPLE_BITS:0]   w_sum;
  logic [1:0]             w_fix;
  logic [15:0]            x_d;
  logic                   d1_vld_q;
  logic [15:0]            x_raw_q;

  always_comb begin
    w_t   = TW'(mask_sample_i) * TW'(WidenRem) + TW'(SmaxInt / 2);
    w_hi  = w_t[TW-1:SAMPLE_BITS];
    w_lo  = w_t[SAMPLE_BITS-1:0];
    w_sum = {1'b0, w_hi} + {1'b0, w_lo};
    if (w_sum >= (SAMPLE_BITS+1)'(2 * SmaxInt)) begin
      w_fix = 2'd2;
    end else if (w_sum >= (SAMPLE_BITS+1)'(SmaxInt)) begin
      w_fix = 2'd1;
    end else begin
      w_fix = 2'd0;
    end
    x_d = 16'(mask_sample_i) * 16'(WidenMul) + 16'(w_hi) + 16'(w_fix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
    end else if (adv) begin
      d1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_raw_q <= x_d;
    end
  end

  // renormalize: zero maps to a zero quotient, full span to exactly one
  logic [15:0] x_inv, dx, dsel;
  logic [32:0] num2_q;
  logic        r_vld_q;

  always_comb begin
    x_inv = invert_q ? ~x_raw_q : x_raw_q;
    dx    = x_inv - black_q;
    if (x_inv <= black_q) begin
      dsel = '0;
    end else if (dx >= span_q) begin
      dsel = span_q;
    end else begin
      dsel = dx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= d1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num2_q <= {1'b0, dsel, 16'd0} + 33'(span_q >> 1);
    end
  end

  logic        d2_vld;
  logic [16:0] norm_raw, norm;

  mlgc_div #(
    .NUM_W (33),
    .DEN_W (16),
    .QUO_W (17)
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (r_vld_q),
    .num_i   (num2_q),
    .den_i   (span_q),
    .valid_o (d2_vld),
    .quo_o   (norm_raw)
  );

  assign norm = (norm_raw > mlgc_pkg::OneQ16) ? mlgc_pkg::OneQ16 : norm_raw;

  logic        s_vld;
  logic [16:0] shaped;

  mlgc_shape u_shape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (d2_vld),
    .norm_i     (norm),
    .exponent_i (exp_clamp_q),
    .valid_o    (s_vld),
    .shaped_o   (shaped)
  );

  // output mapping
  logic               l1_vld_q, l2_vld_q, o_vld_q;
  logic signed [34:0] prod_q;
  logic signed [16:0] odiff;
  logic signed [35:0] lerp;
  logic [31:0]        lv_q;
  logic               disp_q;
  logic [32:0]        lvl_wide;
  logic [LEVEL_BITS-1:0] lvl_d, level_q;

  assign odiff = $signed({1'b0, out_white_q}) - $signed({1'b0, out_black_q});
  assign lerp  = $signed({3'b000, out_black_q, 16'd0}) + 36'(prod_q);

  assign lvl_wide = ({1'b0, lv_q} + LevelRnd) >> (32 - LEVEL_BITS);

  always_comb begin
    lvl_d = '0;
    if (disp_q) begin
      lvl_d = (lvl_wide > 33'(LevelMax)) ? LevelMax : lvl_wide[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_vld_q <= 1'b0;
      l2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (adv) begin
      l1_vld_q <= s_vld;
      l2_vld_q <= l1_vld_q;
      o_vld_q  <= l2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= 35'(odiff) * $signed({18'd0, shaped});
      lv_q    <= lerp[35] ? 32'd0 : lerp[31:0];
      disp_q  <= !lerp[35] && (lerp[31:0] > mlgc_pkg::DispThresh);
      level_q <= lvl_d;
    end
  end

  assign out_valid_o = o_vld_q;
  assign level_o     = level_q;
  assign present_o   = level_q != '0;

endmodule
